FILE: hw/rtl/rfa_pkg.sv
`default_nettype none

package rfa_pkg;

    // Frame sizes: a frame holds at most LEN-1 bytes including the terminator
    localparam int STICK_FRAME_LEN = 10;
    localparam int TILT_FRAME_LEN  = 20;

    localparam int STICK_DEPTH  = STICK_FRAME_LEN - 1;
    localparam int TILT_DEPTH   = TILT_FRAME_LEN - 1;
    localparam int STICK_CNT_W  = $clog2(STICK_DEPTH + 1);
    localparam int TILT_CNT_W   = $clog2(TILT_DEPTH + 1);
    localparam int STICK_ADDR_W = $clog2(STICK_DEPTH);
    localparam int TILT_ADDR_W  = $clog2(TILT_DEPTH);
    localparam int IDX_W = (STICK_ADDR_W > TILT_ADDR_W) ? STICK_ADDR_W : TILT_ADDR_W;

    localparam logic [STICK_CNT_W-1:0] STICK_DEPTH_C = STICK_CNT_W'(STICK_DEPTH);
    localparam logic [STICK_CNT_W-1:0] STICK_FILL_C  = STICK_CNT_W'(STICK_DEPTH - 1);
    localparam logic [TILT_CNT_W-1:0]  TILT_DEPTH_C  = TILT_CNT_W'(TILT_DEPTH);
    localparam logic [TILT_CNT_W-1:0]  TILT_FILL_C   = TILT_CNT_W'(TILT_DEPTH - 1);

    // Job queue between front and back (power of two depth)
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

    // Result queue at the output (power of two depth)
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam logic [OUT_CNT_W-1:0] OUT_DEPTH_C = OUT_CNT_W'(OUT_DEPTH);

    // Character codes
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_G   = 8'h67;
    localparam logic [7:0] CH_MODE_BASE = 8'h60;
    localparam logic [7:0] CH_L         = 8'h4C;
    localparam logic [7:0] CH_R         = 8'h52;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_STAR      = 8'h2A;

    // Mode codes
    localparam logic [2:0] MODE_NONE     = 3'd0;
    localparam logic [2:0] MODE_TILT     = 3'd2;
    localparam logic [2:0] MODE_FILTERED = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LEFT  = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_TILT  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LEFT,
        BK_RIGHT,
        BK_TILT,
        BK_NONE
    } bk_state_t;

    // One job per accepted item: frame lengths to play out, zero for none
    typedef struct packed {
        logic [2:0]             mode;
        logic [STICK_CNT_W-1:0] left_len;
        logic [STICK_CNT_W-1:0] right_len;
        logic [TILT_CNT_W-1:0]  tilt_len;
    } job_t;

    typedef struct packed {
        logic [2:0] mode;
        kind_t      kind;
        logic [7:0] data;
        logic       valid;
        logic       last;
    } res_t;

    typedef struct packed {
        logic                    en;
        logic [STICK_ADDR_W-1:0] addr;
    } stick_port_t;

    typedef struct packed {
        logic                   en;
        logic [TILT_ADDR_W-1:0] addr;
    } tilt_port_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rfa_ram.sv
`default_nettype none

module rfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rfa_job_queue.sv
`default_nettype none

module rfa_job_queue
    import rfa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_job,
    output logic      q_full,
    input  wire logic rd_en,
    output logic      q_empty,
    output job_t      rd_job
);

    job_t                  slot_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wptr_reg, wptr_next;
    logic [JOBQ_PTR_W-1:0] rptr_reg, rptr_next;
    logic [JOBQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_wr, do_rd;

    assign q_full  = (count_reg == JOBQ_CNT_W'(JOBQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = slot_reg[rptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + JOBQ_PTR_W'(1) : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + JOBQ_PTR_W'(1) : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + JOBQ_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - JOBQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Hold job payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rfa_front.sv
`default_nettype none

module rfa_front
    import rfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] rx_byte,
    output logic            full,
    input  wire logic       jq_full,
    output logic            jq_push,
    output job_t            jq_job,
    input  wire logic       frame_done,
    output stick_port_t     left_wr,
    output stick_port_t     right_wr,
    output tilt_port_t      tilt_wr
);

    logic [2:0]             mode_reg, mode_next;
    logic                   m4_reg, m4_next;
    logic                   left_first_reg, left_first_next;
    logic                   right_first_reg, right_first_next;
    logic                   left_active_reg, left_active_next;
    logic                   right_active_reg, right_active_next;
    logic                   tilt_active_reg, tilt_active_next;
    logic [STICK_CNT_W-1:0] left_count_reg, left_count_next;
    logic [STICK_CNT_W-1:0] right_count_reg, right_count_next;
    logic [TILT_CNT_W-1:0]  tilt_count_reg, tilt_count_next;
    logic                   busy_reg, busy_next;

    logic                   accept;
    logic                   is_star;
    logic                   l_act, r_act, t_act;
    logic [STICK_CNT_W-1:0] l_cnt, r_cnt;
    logic [TILT_CNT_W-1:0]  t_base, t_cnt;
    logic                   has_frame;

    // Stall while the job queue is full or a finished frame still waits to be read out of its store
    assign full    = jq_full || busy_reg;
    assign accept  = push && !full;
    assign is_star = (rx_byte == CH_STAR);

    // Classify the item, update assemblers, build the job
    always_comb
    begin
        mode_next         = mode_reg;
        m4_next           = m4_reg;
        left_first_next   = left_first_reg;
        right_first_next  = right_first_reg;
        left_active_next  = left_active_reg;
        right_active_next = right_active_reg;
        tilt_active_next  = tilt_active_reg;
        left_count_next   = left_count_reg;
        right_count_next  = right_count_reg;
        tilt_count_next   = tilt_count_reg;
        left_wr           = '0;
        right_wr          = '0;
        tilt_wr           = '0;
        jq_job            = '0;
        l_act             = 1'b0;
        r_act             = 1'b0;
        t_act             = 1'b0;
        l_cnt             = left_count_reg;
        r_cnt             = right_count_reg;
        t_base            = tilt_count_reg;
        t_cnt             = tilt_count_reg;

        if (accept)
        begin
            if (rx_byte >= CH_LOWER_A && rx_byte <= CH_LOWER_G)
            begin
                mode_next = 3'(rx_byte - CH_MODE_BASE);
            end
            if (!m4_reg && mode_next == MODE_FILTERED)
            begin
                mode_next = MODE_NONE;
                m4_next   = 1'b1;
            end

            if (mode_next != MODE_TILT)
            begin
                // Left assembler
                l_act = left_active_reg || (rx_byte == CH_L);
                left_active_next = l_act;
                if (l_act)
                begin
                    left_wr.en   = is_star || (left_count_reg < STICK_FILL_C);
                    left_wr.addr = (left_count_reg < STICK_DEPTH_C)
                                 ? STICK_ADDR_W'(left_count_reg)
                                 : STICK_ADDR_W'(STICK_DEPTH - 1);
                    if (is_star ? (left_count_reg < STICK_DEPTH_C)
                                : (left_count_reg < STICK_FILL_C))
                    begin
                        l_cnt = left_count_reg + STICK_CNT_W'(1);
                    end
                    left_count_next = l_cnt;
                    if (is_star)
                    begin
                        if (left_first_reg)
                        begin
                            jq_job.left_len = l_cnt;
                        end
                        left_first_next  = 1'b1;
                        left_active_next = 1'b0;
                        left_count_next  = '0;
                    end
                end

                // Right assembler
                r_act = right_active_reg || (rx_byte == CH_R);
                right_active_next = r_act;
                if (r_act)
                begin
                    right_wr.en   = is_star || (right_count_reg < STICK_FILL_C);
                    right_wr.addr = (right_count_reg < STICK_DEPTH_C)
                                  ? STICK_ADDR_W'(right_count_reg)
                                  : STICK_ADDR_W'(STICK_DEPTH - 1);
                    if (is_star ? (right_count_reg < STICK_DEPTH_C)
                                : (right_count_reg < STICK_FILL_C))
                    begin
                        r_cnt = right_count_reg + STICK_CNT_W'(1);
                    end
                    right_count_next = r_cnt;
                    if (is_star)
                    begin
                        if (right_first_reg)
                        begin
                            jq_job.right_len = r_cnt;
                        end
                        right_first_next  = 1'b1;
                        right_active_next = 1'b0;
                        right_count_next  = '0;
                    end
                end
            end
            else
            begin
                // Tilt assembler: a header restarts at index zero
                if (rx_byte == CH_UPPER_A)
                begin
                    t_base = '0;
                end
                t_cnt = t_base;
                t_act = tilt_active_reg || (rx_byte == CH_UPPER_A);
                tilt_active_next = t_act;
                if (t_act)
                begin
                    tilt_wr.en   = is_star || (t_base < TILT_FILL_C);
                    tilt_wr.addr = (t_base < TILT_DEPTH_C)
                                 ? TILT_ADDR_W'(t_base)
                                 : TILT_ADDR_W'(TILT_DEPTH - 1);
                    if (is_star ? (t_base < TILT_DEPTH_C) : (t_base < TILT_FILL_C))
                    begin
                        t_cnt = t_base + TILT_CNT_W'(1);
                    end
                    tilt_count_next = t_cnt;
                    if (is_star)
                    begin
                        jq_job.tilt_len  = t_cnt;
                        tilt_active_next = 1'b0;
                        tilt_count_next  = '0;
                    end
                end
                else
                begin
                    tilt_count_next = t_base;
                end
            end
            jq_job.mode = mode_next;
        end
    end

    assign jq_push   = accept;
    assign has_frame = (jq_job.left_len != '0) || (jq_job.right_len != '0)
                    || (jq_job.tilt_len != '0);

    // Track a frame job in flight until the back has read its store
    always_comb
    begin
        busy_next = busy_reg;
        if (accept && has_frame)
        begin
            busy_next = 1'b1;
        end
        else if (frame_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NONE;
            m4_reg           <= 1'b0;
            left_first_reg   <= 1'b0;
            right_first_reg  <= 1'b0;
            left_active_reg  <= 1'b0;
            right_active_reg <= 1'b0;
            tilt_active_reg  <= 1'b0;
            left_count_reg   <= '0;
            right_count_reg  <= '0;
            tilt_count_reg   <= '0;
            busy_reg         <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            m4_reg           <= m4_next;
            left_first_reg   <= left_first_next;
            right_first_reg  <= right_first_next;
            left_active_reg  <= left_active_next;
            right_active_reg <= right_active_next;
            tilt_active_reg  <= tilt_active_next;
            left_count_reg   <= left_count_next;
            right_count_reg  <= right_count_next;
            tilt_count_reg   <= tilt_count_next;
            busy_reg         <= busy_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rfa_back.sv
`default_nettype none

module rfa_back
    import rfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       jq_empty,
    input  wire job_t       jq_job,
    output logic            jq_pop,
    output logic            frame_done,
    output stick_port_t     left_rd,
    output stick_port_t     right_rd,
    output tilt_port_t      tilt_rd,
    input  wire logic [7:0] left_rdata,
    input  wire logic [7:0] right_rdata,
    input  wire logic [7:0] tilt_rdata,
    output logic            empty,
    input  wire logic       pop,
    output res_t            head
);

    bk_state_t             state_reg, state_next;
    job_t                  job_reg, job_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  pipe_valid_reg;
    res_t                  pipe_res_reg, pipe_res_next;
    res_t                  out_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [OUT_CNT_W-1:0]  count_reg, count_next;
    logic [OUT_CNT_W-1:0]  occ;
    logic                  can_issue;
    logic                  issue;
    logic                  is_end;
    logic [IDX_W-1:0]      end_idx;
    logic                  out_pop;
    res_t                  push_res;

    // Issue only when the result queue has room for what is in flight
    assign occ       = count_reg + OUT_CNT_W'(pipe_valid_reg);
    assign can_issue = (occ < OUT_DEPTH_C);

    // Last index of the frame being played out
    always_comb
    begin
        unique case (state_reg)
            BK_LEFT:  end_idx = IDX_W'(job_reg.left_len - STICK_CNT_W'(1));
            BK_RIGHT: end_idx = IDX_W'(job_reg.right_len - STICK_CNT_W'(1));
            BK_TILT:  end_idx = IDX_W'(job_reg.tilt_len - TILT_CNT_W'(1));
            default:  end_idx = '0;
        endcase
    end

    assign is_end = (idx_reg == end_idx);

    // Next state: walk left, right, tilt frames of the job in order
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!jq_empty)
                begin
                    if (jq_job.left_len != '0)
                    begin
                        state_next = BK_LEFT;
                    end
                    else if (jq_job.right_len != '0)
                    begin
                        state_next = BK_RIGHT;
                    end
                    else if (jq_job.tilt_len != '0)
                    begin
                        state_next = BK_TILT;
                    end
                    else
                    begin
                        state_next = BK_NONE;
                    end
                end
            end
            BK_LEFT:
            begin
                if (can_issue && is_end)
                begin
                    if (job_reg.right_len != '0)
                    begin
                        state_next = BK_RIGHT;
                    end
                    else if (job_reg.tilt_len != '0)
                    begin
                        state_next = BK_TILT;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_RIGHT:
            begin
                if (can_issue && is_end)
                begin
                    state_next = (job_reg.tilt_len != '0) ? BK_TILT : BK_IDLE;
                end
            end
            BK_TILT:
            begin
                if (can_issue && is_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_NONE:
            begin
                if (can_issue)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs: read strobes, result tag, index advance
    always_comb
    begin
        jq_pop        = 1'b0;
        issue         = 1'b0;
        pipe_res_next = '0;
        left_rd       = '0;
        right_rd      = '0;
        tilt_rd       = '0;
        job_next      = job_reg;
        pipe_res_next.mode = job_reg.mode;
        unique case (state_reg)
            BK_IDLE:
            begin
                jq_pop = !jq_empty;
                if (!jq_empty)
                begin
                    job_next = jq_job;
                end
            end
            BK_LEFT:
            begin
                issue               = can_issue;
                left_rd.en          = can_issue;
                left_rd.addr        = STICK_ADDR_W'(idx_reg);
                pipe_res_next.kind  = KIND_LEFT;
                pipe_res_next.valid = 1'b1;
                pipe_res_next.last  = is_end && (job_reg.right_len == '0)
                                   && (job_reg.tilt_len == '0);
            end
            BK_RIGHT:
            begin
                issue               = can_issue;
                right_rd.en         = can_issue;
                right_rd.addr       = STICK_ADDR_W'(idx_reg);
                pipe_res_next.kind  = KIND_RIGHT;
                pipe_res_next.valid = 1'b1;
                pipe_res_next.last  = is_end && (job_reg.tilt_len == '0);
            end
            BK_TILT:
            begin
                issue               = can_issue;
                tilt_rd.en          = can_issue;
                tilt_rd.addr        = TILT_ADDR_W'(idx_reg);
                pipe_res_next.kind  = KIND_TILT;
                pipe_res_next.valid = 1'b1;
                pipe_res_next.last  = is_end;
            end
            BK_NONE:
            begin
                issue               = can_issue;
                pipe_res_next.kind  = KIND_NONE;
                pipe_res_next.last  = 1'b1;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign frame_done = issue && pipe_res_next.last && (state_reg != BK_NONE);

    always_comb
    begin
        idx_next = idx_reg;
        if (issue && state_reg != BK_NONE)
        begin
            idx_next = is_end ? '0 : idx_reg + IDX_W'(1);
        end
    end

    // Merge read data into the staged result
    always_comb
    begin
        push_res = pipe_res_reg;
        unique case (pipe_res_reg.kind)
            KIND_LEFT:  push_res.data = left_rdata;
            KIND_RIGHT: push_res.data = right_rdata;
            KIND_TILT:  push_res.data = tilt_rdata;
            KIND_NONE:  push_res.data = 8'h00;
        endcase
    end

    assign empty   = (count_reg == '0);
    assign out_pop = pop && !empty;
    assign head    = out_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (pipe_valid_reg && !out_pop)
        begin
            count_next = count_reg + OUT_CNT_W'(1);
        end
        else if (out_pop && !pipe_valid_reg)
        begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            idx_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            wptr_reg       <= '0;
            rptr_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pipe_valid_reg <= issue;
            count_reg      <= count_next;
            if (pipe_valid_reg)
            begin
                wptr_reg <= wptr_reg + OUT_PTR_W'(1);
            end
            if (out_pop)
            begin
                rptr_reg <= rptr_reg + OUT_PTR_W'(1);
            end
        end
    end

    // Hold payload: current job, staged result, result queue
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (issue)
        begin
            pipe_res_reg <= pipe_res_next;
        end
        if (pipe_valid_reg)
        begin
            out_reg[wptr_reg] <= push_res;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/remote_frame_assembler_unit.sv
`default_nettype none

// An item that delivers frames gives one result per frame byte, other items one result each;
// frame bytes are read one per cycle from a frame store while the result queue has room.
// A new item is held off while a finished frame is still read out of its store.
// Reset: asynchronous, active low; clears mode, assembler and queue state,
// frame stores are not cleared.
module remote_frame_assembler_unit
    import rfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      mode_code,
    output logic [1:0]      frame_kind,
    output logic [7:0]      frame_byte,
    output logic            byte_valid,
    output logic            last
);

    logic        jq_full, jq_empty, jq_push, jq_pop;
    job_t        wr_job, rd_job;
    logic        frame_done;
    stick_port_t left_wr, right_wr, left_rd, right_rd;
    tilt_port_t  tilt_wr, tilt_rd;
    logic [7:0]  left_rdata, right_rdata, tilt_rdata;
    res_t        head;

    rfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rx_byte    (rx_byte),
        .full       (full),
        .jq_full    (jq_full),
        .jq_push    (jq_push),
        .jq_job     (wr_job),
        .frame_done (frame_done),
        .left_wr    (left_wr),
        .right_wr   (right_wr),
        .tilt_wr    (tilt_wr)
    );

    rfa_job_queue u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (jq_push),
        .wr_job  (wr_job),
        .q_full  (jq_full),
        .rd_en   (jq_pop),
        .q_empty (jq_empty),
        .rd_job  (rd_job)
    );

    rfa_ram #(.WIDTH(8), .DEPTH(STICK_DEPTH)) u_left_ram (
        .clk   (clk),
        .we    (left_wr.en),
        .waddr (left_wr.addr),
        .wdata (rx_byte),
        .re    (left_rd.en),
        .raddr (left_rd.addr),
        .rdata (left_rdata)
    );

    rfa_ram #(.WIDTH(8), .DEPTH(STICK_DEPTH)) u_right_ram (
        .clk   (clk),
        .we    (right_wr.en),
        .waddr (right_wr.addr),
        .wdata (rx_byte),
        .re    (right_rd.en),
        .raddr (right_rd.addr),
        .rdata (right_rdata)
    );

    rfa_ram #(.WIDTH(8), .DEPTH(TILT_DEPTH)) u_tilt_ram (
        .clk   (clk),
        .we    (tilt_wr.en),
        .waddr (tilt_wr.addr),
        .wdata (rx_byte),
        .re    (tilt_rd.en),
        .raddr (tilt_rd.addr),
        .rdata (tilt_rdata)
    );

    rfa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .jq_empty    (jq_empty),
        .jq_job      (rd_job),
        .jq_pop      (jq_pop),
        .frame_done  (frame_done),
        .left_rd     (left_rd),
        .right_rd    (right_rd),
        .tilt_rd     (tilt_rd),
        .left_rdata  (left_rdata),
        .right_rdata (right_rdata),
        .tilt_rdata  (tilt_rdata),
        .empty       (empty),
        .pop         (pop),
        .head        (head)
    );

    // Drive result ports from the queue head
    assign mode_code  = head.mode;
    assign frame_kind = head.kind;
    assign frame_byte = head.data;
    assign byte_valid = head.valid;
    assign last       = head.last;

endmodule

`default_nettype wire

FILE: tb/tb_remote_frame_assembler_unit.sv
`default_nettype none

module tb_remote_frame_assembler_unit;
    import rfa_pkg::*;

    localparam int RANDOM_BYTES = 90;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [2:0] mode_code;
    logic [1:0] frame_kind;
    logic [7:0] frame_byte;
    logic       byte_valid;
    logic       last;

    // Predicted receiver state
    logic [2:0] mode_now = MODE_NONE;
    bit         mode4_used = 1'b0;
    bit         left_seen = 1'b0;
    bit         right_seen = 1'b0;
    bit         left_open = 1'b0;
    bit         right_open = 1'b0;
    bit         tilt_open = 1'b0;
    int         left_len = 0;
    int         right_len = 0;
    int         tilt_len = 0;
    logic [7:0] left_frame  [STICK_DEPTH];
    logic [7:0] right_frame [STICK_DEPTH];
    logic [7:0] tilt_frame  [TILT_DEPTH];

    res_t       results_due [$];
    res_t       head_due;

    bit         steady_flow = 1'b0;
    bit         long_tilt_sent = 1'b0;
    int         pop_hold = 0;
    int         cycle_count = 0;
    int         bytes_sent = 0;
    int         results_checked = 0;
    int         frame_bytes_checked = 0;
    int         tilt_bytes_checked = 0;
    int         mismatch_count = 0;

    remote_frame_assembler_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .empty      (empty),
        .pop        (pop),
        .mode_code  (mode_code),
        .frame_kind (frame_kind),
        .frame_byte (frame_byte),
        .byte_valid (byte_valid),
        .last       (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Pick an idle stretch: mostly none, some short, a few long
    function automatic int idle_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [7:0] mode_letter(input int m);
        return CH_MODE_BASE + 8'(m);
    endfunction

    // Frame content: any byte except the terminator and the mode letters
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_STAR || (b >= CH_LOWER_A && b <= CH_LOWER_G))
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic res_t frame_result(input kind_t k, input logic [7:0] d, input logic v);
        res_t r;
        r.mode  = mode_now;
        r.kind  = k;
        r.data  = d;
        r.valid = v;
        r.last  = 1'b0;
        return r;
    endfunction

    // Advance the predicted receiver by one byte and queue the results it causes
    task automatic predict_frames(input logic [7:0] b);
        res_t step_q [$];
        res_t r;
        int   i;
        if (b >= CH_LOWER_A && b <= CH_LOWER_G)
            mode_now = 3'(b - CH_MODE_BASE);
        if (!mode4_used && mode_now == MODE_FILTERED)
        begin
            mode_now   = MODE_NONE;
            mode4_used = 1'b1;
        end
        if (mode_now != MODE_TILT)
        begin
            // left assembler; the terminator always fits
            if (b == CH_L)
                left_open = 1'b1;
            if (left_open)
            begin
                if (b == CH_STAR || left_len < STICK_DEPTH - 1)
                begin
                    left_frame[left_len] = b;
                    left_len++;
                end
                if (b == CH_STAR)
                begin
                    if (left_seen)
                        for (i = 0; i < left_len; i++)
                            step_q.push_back(frame_result(KIND_LEFT, left_frame[i], 1'b1));
                    left_seen = 1'b1;
                    left_open = 1'b0;
                    left_len  = 0;
                end
            end
            // right assembler sees the same bytes
            if (b == CH_R)
                right_open = 1'b1;
            if (right_open)
            begin
                if (b == CH_STAR || right_len < STICK_DEPTH - 1)
                begin
                    right_frame[right_len] = b;
                    right_len++;
                end
                if (b == CH_STAR)
                begin
                    if (right_seen)
                        for (i = 0; i < right_len; i++)
                            step_q.push_back(frame_result(KIND_RIGHT, right_frame[i], 1'b1));
                    right_seen = 1'b1;
                    right_open = 1'b0;
                    right_len  = 0;
                end
            end
        end
        else
        begin
            // tilt assembler; a header restarts it
            if (b == CH_UPPER_A)
            begin
                tilt_open = 1'b1;
                tilt_len  = 0;
            end
            if (tilt_open)
            begin
                if (b == CH_STAR || tilt_len < TILT_DEPTH - 1)
                begin
                    tilt_frame[tilt_len] = b;
                    tilt_len++;
                end
                if (b == CH_STAR)
                begin
                    for (i = 0; i < tilt_len; i++)
                        step_q.push_back(frame_result(KIND_TILT, tilt_frame[i], 1'b1));
                    tilt_open = 1'b0;
                    tilt_len  = 0;
                end
            end
        end
        if (step_q.size() == 0)
            step_q.push_back(frame_result(KIND_NONE, 8'h00, 1'b0));
        r = step_q.pop_back();
        r.last = 1'b1;
        step_q.push_back(r);
        foreach (step_q[i])
            results_due.push_back(step_q[i]);
    endtask

    // Offer one item after a random gap, hold it until accepted
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_frames(b);
        bytes_sent++;
    endtask

    // Hold the sender until every queued result has been taken
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("ERROR result %0d: %s got 0x%0h, want 0x%0h",
                 results_checked, what, got, want_v);
        mismatch_count++;
    endtask

    // Receiver stalls at random unless the flow is steady
    always @(negedge clk)
    begin
        if (steady_flow)
            pop <= 1'b1;
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold = pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            pop_hold = idle_gap();
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (results_due.size() == 0)
                report_mismatch("result with nothing expected, frame_byte", frame_byte, 0);
            else
            begin
                head_due = results_due.pop_front();
                if (mode_code !== head_due.mode)
                    report_mismatch("mode_code", mode_code, head_due.mode);
                if (frame_kind !== head_due.kind)
                    report_mismatch("frame_kind", frame_kind, head_due.kind);
                if (frame_byte !== head_due.data)
                    report_mismatch("frame_byte", frame_byte, head_due.data);
                if (byte_valid !== head_due.valid)
                    report_mismatch("byte_valid", byte_valid, head_due.valid);
                if (last !== head_due.last)
                    report_mismatch("last", last, head_due.last);
                if (head_due.valid)
                    frame_bytes_checked++;
                if (head_due.kind == KIND_TILT)
                    tilt_bytes_checked++;
            end
            results_checked++;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // First 'd' is turned into mode 0
    task automatic test_mode_filter();
        send_rx_byte(mode_letter(MODE_FILTERED));
    endtask

    // First left and first right frames give no bytes
    task automatic test_first_frames_swallowed();
        send_rx_byte(CH_L);
        send_rx_byte(CH_R);
        send_rx_byte(CH_STAR);
    endtask

    // Both assemblers open at once, extremes of the byte as content
    task automatic test_shared_bytes();
        send_rx_byte(CH_L);
        send_rx_byte(CH_R);
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(CH_STAR);
    endtask

    // Left frame parked across a tilt frame that restarts on a second header
    task automatic test_mode_switch_and_tilt_restart();
        send_rx_byte(CH_L);
        send_rx_byte(mode_letter(3));
        send_rx_byte(mode_letter(MODE_TILT));
        send_rx_byte(CH_UPPER_A);
        send_rx_byte(8'h7F);
        send_rx_byte(CH_UPPER_A);
        send_rx_byte(8'h7A);
        send_rx_byte(CH_STAR);
        send_rx_byte(mode_letter(5));
        send_rx_byte(CH_STAR);
    endtask

    // Real mode 4, repeated header, stick frame overflow
    task automatic test_stick_overflow();
        send_rx_byte(mode_letter(MODE_FILTERED));
        send_rx_byte(mode_letter(7));
        send_rx_byte(CH_L);
        send_rx_byte(CH_L);
        send_rx_byte(8'h30);
        send_rx_byte(mode_letter(1));
        send_rx_byte(8'h31);
        send_rx_byte(mode_letter(6));
        send_rx_byte(8'h32);
        send_rx_byte(8'h80);
        send_rx_byte(8'h33);
        send_rx_byte(8'h34);
        send_rx_byte(CH_STAR);
    endtask

    task automatic send_stick_frame();
        int shape;
        int len;
        int split;
        int i;
        int m;
        if (mode_now == MODE_TILT)
        begin
            m = $urandom_range(1, 6);
            if (m >= MODE_TILT)
                m++;
            send_rx_byte(mode_letter(m));
        end
        shape = $urandom_range(0, 2);
        len   = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 6);
        split = $urandom_range(0, len);
        send_rx_byte((shape == 1) ? CH_R : CH_L);
        for (i = 0; i < len; i++)
        begin
            if (shape == 2 && i == split)
                send_rx_byte(CH_R);
            send_rx_byte(body_byte());
        end
        if (shape == 2 && split == len)
            send_rx_byte(CH_R);
        // now and then leave the frame open
        if ($urandom_range(0, 9) != 0)
            send_rx_byte(CH_STAR);
    endtask

    task automatic send_tilt_frame();
        int len;
        int i;
        if (mode_now != MODE_TILT)
            send_rx_byte(mode_letter(MODE_TILT));
        if (!long_tilt_sent || $urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(16, 22);
            long_tilt_sent = 1'b1;
        end
        else
            len = $urandom_range(0, 8);
        send_rx_byte(CH_UPPER_A);
        for (i = 0; i < len; i++)
            send_rx_byte(body_byte());
        if ($urandom_range(0, 9) != 0)
            send_rx_byte(CH_STAR);
    endtask

    // Mostly well-formed frames with random content, some noise
    task automatic test_random_traffic();
        int  action;
        int  first_byte;
        bit  drained;
        drained    = 1'b0;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            steady_flow = (bytes_sent - first_byte >= 30) && (bytes_sent - first_byte < 50);
            if (!drained && bytes_sent - first_byte >= 65)
            begin
                wait_drained();
                drained = 1'b1;
            end
            action = $urandom_range(0, 99);
            if (action < 10)
                send_rx_byte(8'($urandom_range(0, 255)));
            else if (action < 18)
                send_rx_byte(mode_letter($urandom_range(1, 7)));
            else if (action < 40)
                send_tilt_frame();
            else
                send_stick_frame();
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_mode_filter();
        test_first_frames_swallowed();
        test_shared_bytes();
        test_mode_switch_and_tilt_restart();
        test_stick_overflow();
        test_random_traffic();

        // drain and let the pipeline settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run sent %0d bytes and checked %0d results in %0d cycles.",
                 bytes_sent, results_checked, cycle_count);
        $display("Frame bytes seen: %0d, of them %0d from tilt frames.",
                 frame_bytes_checked, tilt_bytes_checked);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

FILE: remote_frame_assembler_unit.f
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_ram.sv
hw/rtl/rfa_job_queue.sv
hw/rtl/rfa_front.sv
hw/rtl/rfa_back.sv
hw/rtl/remote_frame_assembler_unit.sv
tb/tb_remote_frame_assembler_unit.sv
